// ----- src/next_seven_smooth_size_assert.svh -----
// Assertion macros used by the top module of the smooth-size search block.
`ifndef NEXT_SEVEN_SMOOTH_SIZE_ASSERT_SVH
`define NEXT_SEVEN_SMOOTH_SIZE_ASSERT_SVH
`ifndef ASSERT_OFF
`define NSSS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define NSSS_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define NSSS_ASSERT(label, clk, rstn, prop, msg)
`define NSSS_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// ----- src/nsss_pkg.sv -----
// Types shared by the modules of the smooth-size search block.
package nsss_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EVAL,
        ST_STEP3,
        ST_STEP5,
        ST_STEP7,
        ST_DONE
    } nsss_state_t;

    typedef enum logic [1:0] {
        SCALE_BY3,
        SCALE_BY5,
        SCALE_BY7
    } nsss_scale_t;

endpackage

// ----- src/next_seven_smooth_size.sv -----
// Top level of the search for the smallest 7-smooth size not below a minimum.
//
// An item on the s_ channel (s_min_size) asks for the smallest integer of the
// form 2^a * 3^b * 5^c * 7^d that is not below s_min_size; the answer leaves on
// the m_ channel as m_good_size, one result per item, in order.
// Each odd base 3^b * 5^c * 7^d below the current best value is brought up to
// the target by a shared shift unit in SHIFT steps of halving power-of-two
// amounts, then checked in the EVAL state; one shared shift-add/subtract unit
// forms the next base, once per visit of a loop level. Inputs of 0 or 1 skip
// the search and go straight to the DONE state.
// s_ready is high only while the sequencer is idle, one item at a time.
// The result is held in an output register, so the next item is accepted while
// a result waits; a stalled receiver only holds the block once a second result
// is ready. Reset clears the sequencer and drops any pending result.
`include "next_seven_smooth_size_assert.svh"
module next_seven_smooth_size
    import nsss_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SIZE_BITS-1:0] s_min_size,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SIZE_BITS:0]   m_good_size
);
    localparam int W  = SIZE_BITS + 1;
    localparam int SW = $clog2(SIZE_BITS + 1);
    localparam int JB = $clog2(SW);

    nsss_state_t          state_reg, state_next;
    logic                 init_reg, init_next;
    logic                 m_valid_reg, m_valid_next;
    logic [W-1:0]         m_data_reg, m_data_next;
    logic [SIZE_BITS-1:0] t_reg, t_next;
    logic [W-1:0]         best_reg, best_next;
    logic [W-1:0]         cur_reg, cur_next;
    logic [W-1:0]         p3_reg, p3_next;
    logic [W-1:0]         p5_reg, p5_next;
    logic [W-1:0]         p7_reg, p7_next;
    logic [JB-1:0]        step_reg, step_next;

    logic [SIZE_BITS-1:0] tm1;
    logic [W-1:0]         shift_out;
    nsss_scale_t          scale_sel;
    logic [W-1:0]         scale_base;
    logic [W-1:0]         scale_prod;
    logic                 scale_below;
    logic [W-1:0]         eval_val;

    assign tm1 = t_reg - SIZE_BITS'(1);

    nsss_shift_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_shift (
        .cur      (cur_reg),
        .tm1      (tm1),
        .step_idx (step_reg),
        .cur_next (shift_out)
    );

    nsss_scale_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_scale (
        .factor (scale_sel),
        .base   (scale_base),
        .best   (best_reg),
        .prod   (scale_prod),
        .below  (scale_below)
    );

    assign eval_val = (cur_reg < {1'b0, t_reg}) ? (cur_reg << 1) : cur_reg;

    always_comb begin
        case (state_reg)
            ST_STEP5: begin
                scale_sel  = SCALE_BY5;
                scale_base = p5_reg;
            end
            ST_STEP7: begin
                scale_sel  = SCALE_BY7;
                scale_base = p7_reg;
            end
            default: begin
                scale_sel  = SCALE_BY3;
                scale_base = p3_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            init_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        t_reg      <= t_next;
        best_reg   <= best_next;
        cur_reg    <= cur_next;
        p3_reg     <= p3_next;
        p5_reg     <= p5_next;
        p7_reg     <= p7_next;
        step_reg   <= step_next;
    end

    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        t_next       = t_reg;
        best_next    = best_reg;
        cur_next     = cur_reg;
        p3_next      = p3_reg;
        p5_next      = p5_reg;
        p7_next      = p7_reg;
        step_next    = step_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    t_next = s_min_size;
                    if (s_min_size <= SIZE_BITS'(1)) begin
                        best_next  = W'(1);
                        state_next = ST_DONE;
                    end else begin
                        cur_next   = W'(1);
                        step_next  = JB'(SW - 1);
                        init_next  = 1'b1;
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                cur_next = shift_out;
                if (step_reg == '0) begin
                    state_next = ST_EVAL;
                end else begin
                    step_next = step_reg - JB'(1);
                end
            end
            ST_EVAL: begin
                // The first pass on the base one yields the starting power of two.
                if (init_reg) begin
                    best_next = eval_val;
                    init_next = 1'b0;
                    p3_next   = W'(1);
                    p5_next   = W'(1);
                    p7_next   = W'(1);
                end else if (eval_val < best_reg) begin
                    best_next = eval_val;
                end
                state_next = ST_STEP3;
            end
            ST_STEP3: begin
                if (scale_below) begin
                    p3_next    = scale_prod;
                    cur_next   = scale_prod;
                    step_next  = JB'(SW - 1);
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_STEP5;
                end
            end
            ST_STEP5: begin
                if (scale_below) begin
                    p5_next    = scale_prod;
                    p3_next    = scale_prod;
                    cur_next   = scale_prod;
                    step_next  = JB'(SW - 1);
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_STEP7;
                end
            end
            ST_STEP7: begin
                if (scale_below) begin
                    p7_next    = scale_prod;
                    p5_next    = scale_prod;
                    p3_next    = scale_prod;
                    cur_next   = scale_prod;
                    step_next  = JB'(SW - 1);
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = best_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_good_size = m_data_reg;

    `NSSS_ASSERT(a_result_not_below, aclk, aresetn, (state_reg == ST_DONE) |-> (best_reg >= {1'b0, t_reg}), "result below the target")
    `NSSS_ASSERT(a_result_bounded, aclk, aresetn, ((state_reg == ST_DONE) && (t_reg != '0)) |-> (best_reg < {t_reg, 1'b0}), "result not below twice the target")
    `NSSS_NEVER(a_base_order, aclk, aresetn, ((state_reg == ST_STEP3) || (state_reg == ST_STEP5) || (state_reg == ST_STEP7)) && ((p3_reg < p5_reg) || (p5_reg < p7_reg)), "odd bases out of order")

endmodule

// ----- src/nsss_shift_unit.sv -----
// One step of the greedy doubling search: shift by a power of two if the result stays below the target.
module nsss_shift_unit #(
    parameter int SIZE_BITS = 32
) (
    input  logic [SIZE_BITS:0]                             cur,
    input  logic [SIZE_BITS-1:0]                           tm1,
    input  logic [$clog2($clog2(SIZE_BITS+1))-1:0]         step_idx,
    output logic [SIZE_BITS:0]                             cur_next
);
    localparam int SW = $clog2(SIZE_BITS + 1);

    logic [SW-1:0]        amt;
    logic [SIZE_BITS-1:0] lim;
    logic                 fits;

    // cur * 2^amt < T holds exactly when cur <= (T - 1) >> amt.
    assign amt      = SW'(1) << step_idx;
    assign lim      = tm1 >> amt;
    assign fits     = cur <= {1'b0, lim};
    assign cur_next = fits ? (cur << amt) : cur;

endmodule

// ----- src/nsss_scale_unit.sv -----
// Multiplies an odd base by 3, 5 or 7 with shift-add or shift-subtract and compares the product with the best value.
module nsss_scale_unit
    import nsss_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  nsss_scale_t          factor,
    input  logic [SIZE_BITS:0]   base,
    input  logic [SIZE_BITS:0]   best,
    output logic [SIZE_BITS:0]   prod,
    output logic                 below
);
    localparam int W  = SIZE_BITS + 1;
    localparam int PW = W + 3;

    logic [PW-1:0] ext;
    logic [PW-1:0] full;

    assign ext = {3'b000, base};

    always_comb begin
        case (factor)
            SCALE_BY3: full = ext + (ext << 1);
            SCALE_BY5: full = ext + (ext << 2);
            SCALE_BY7: full = (ext << 3) - ext;
            default:   full = '1;
        endcase
    end

    assign below = full < {3'b000, best};
    assign prod  = full[W-1:0];

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the next_seven_smooth_size search block.
`timescale 1ns / 100ps
module tb;

    localparam int SB = 32;
    localparam int RAND_ITEMS = 1145;
    localparam int TAIL_ITEMS = 100;

    typedef struct {
        logic [SB-1:0] min_size;
        bit            drain;
    } size_req_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [SB-1:0] s_min_size = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [SB:0]   m_good_size;

    size_req_t   size_req_q[$];
    logic [SB:0] good_size_q[$];
    int          n_sent = 0;
    int          n_rcvd = 0;
    int          n_total = 0;
    int          n_fail = 0;
    logic        long_hold = 1'b0;

    next_seven_smooth_size #(.SIZE_BITS(SB)) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_min_size  (s_min_size),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_good_size (m_good_size)
    );

    always #5 aclk = ~aclk;

    function automatic logic [SB:0] smallest_smooth_size(input logic [SB-1:0] min_size);
        logic [63:0] goal;
        logic [63:0] best;
        logic [63:0] p7;
        logic [63:0] p5;
        logic [63:0] p3;
        logic [63:0] cand;
        goal = {32'd0, min_size};
        if (goal <= 64'd1) begin
            return (SB + 1)'(1);
        end
        best = 64'd1;
        while (best < goal) best = best << 1;
        for (p7 = 64'd1; p7 < best; p7 = p7 * 7) begin
            for (p5 = p7; p5 < best; p5 = p5 * 5) begin
                for (p3 = p5; p3 < best; p3 = p3 * 3) begin
                    cand = p3;
                    while (cand < goal) cand = cand << 1;
                    if (cand < best) begin
                        best = cand;
                    end
                end
            end
        end
        return best[SB:0];
    endfunction

    // Mostly short sizes, some near 7-smooth values, and a few full-width sizes.
    function automatic logic [SB-1:0] random_min_size();
        logic [63:0] v;
        int          w;
        int          f;
        case ($urandom_range(0, 7))
            0: begin
                v = {32'd0, $urandom};
            end
            1, 2: begin
                v = 64'd1;
                repeat ($urandom_range(1, 30)) begin
                    case ($urandom_range(0, 3))
                        0: f = 2;
                        1: f = 3;
                        2: f = 5;
                        default: f = 7;
                    endcase
                    if (v * f < (64'd1 << SB)) begin
                        v = v * f;
                    end
                end
                v = v + $urandom_range(0, 2) - 1;
            end
            default: begin
                w = $urandom_range(1, 20);
                v = {32'd0, $urandom} & ((64'd1 << w) - 1);
            end
        endcase
        return v[SB-1:0];
    endfunction

    task automatic queue_size(input logic [SB-1:0] min_size, input bit drain);
        size_req_t req;
        req.min_size = min_size;
        req.drain = drain;
        size_req_q.insert(size_req_q.size(), req);
    endtask

    initial begin
        queue_size(32'd0, 1'b0);
        queue_size(32'd1, 1'b0);
        queue_size(32'd2, 1'b0);
        queue_size(32'd3, 1'b0);
        queue_size(32'd4, 1'b0);
        queue_size(32'd5, 1'b0);
        queue_size(32'd7, 1'b0);
        queue_size(32'd11, 1'b0);
        queue_size(32'd13, 1'b0);
        queue_size(32'd17, 1'b0);
        queue_size(32'd1000, 1'b0);
        queue_size(32'd1025, 1'b0);
        queue_size(32'hFFFF_FFFF, 1'b0);
        queue_size(32'h8000_0000, 1'b0);
        queue_size(32'h8000_0001, 1'b0);
        queue_size(32'h7FFF_FFFF, 1'b0);
        queue_size(32'd1977326743, 1'b0);
        queue_size(32'd1977326744, 1'b0);
        queue_size(32'd3486784401, 1'b0);
        queue_size(32'd3486784402, 1'b0);
        queue_size(32'd1220703125, 1'b0);
        queue_size(32'd1220703126, 1'b0);
        queue_size(32'hAAAA_AAAA, 1'b0);
        queue_size(32'h5555_5555, 1'b0);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            queue_size(random_min_size(), i == 0 || i == 500 || i == 900);
        end
        n_total = size_req_q.size();
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin : drive
        int  gap_cnt;
        bit  idle_en;
        bit  busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_min_size <= '0;
            gap_cnt = 0;
            idle_en = 1'b1;
        end else begin
            busy = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                good_size_q.insert(good_size_q.size(), smallest_smooth_size(s_min_size));
                n_sent++;
                if (n_sent % 40 == 0) begin
                    idle_en = $urandom_range(0, 2) != 0;
                end
            end
            if (size_req_q.size() < TAIL_ITEMS) begin
                idle_en = 1'b0;
                gap_cnt = 0;
            end
            if (!busy) begin
                if (gap_cnt != 0) begin
                    gap_cnt--;
                    s_valid <= 1'b0;
                end else if (size_req_q.size() != 0 &&
                             !(size_req_q[0].drain && good_size_q.size() != 0)) begin
                    if (idle_en && $urandom_range(0, 3) == 0) begin
                        gap_cnt = $urandom_range(1, 6) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_min_size <= size_req_q[0].min_size;
                        void'(size_req_q.pop_front());
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch
        int          gap_cnt;
        bit          idle_en;
        logic [SB:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            gap_cnt = 0;
            idle_en = 1'b1;
        end else begin
            if (m_valid && m_ready) begin
                n_rcvd++;
                if (n_rcvd % 40 == 0) begin
                    idle_en = $urandom_range(0, 2) != 0;
                end
                if (good_size_q.size() == 0) begin
                    $error("good_size: no item expected, actual %0d", m_good_size);
                    n_fail++;
                end else begin
                    want = good_size_q.pop_front();
                    if (m_good_size !== want) begin
                        $error("good_size: expected %0d, actual %0d", want, m_good_size);
                        n_fail++;
                    end
                end
            end
            if (size_req_q.size() < TAIL_ITEMS) begin
                idle_en = 1'b0;
                gap_cnt = 0;
            end
            if (long_hold) begin
                m_ready <= 1'b0;
            end else if (gap_cnt != 0) begin
                gap_cnt--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                gap_cnt = $urandom_range(1, 6) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // The receiver stops for long stretches so that the block backs up.
    initial begin
        while (n_sent < 200) @(posedge aclk);
        long_hold <= 1'b1;
        repeat (1500) @(posedge aclk);
        long_hold <= 1'b0;
        while (n_sent < 700) @(posedge aclk);
        long_hold <= 1'b1;
        repeat (3000) @(posedge aclk);
        long_hold <= 1'b0;
    end

    initial begin
        @(posedge aclk);
        while (n_total == 0 || n_sent < n_total) @(posedge aclk);
        while (good_size_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (n_fail == 0) begin
            $display("next_seven_smooth_size test passed");
        end else begin
            $display("next_seven_smooth_size test failed");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("next_seven_smooth_size test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/nsss_pkg.sv
src/nsss_shift_unit.sv
src/nsss_scale_unit.sv
src/next_seven_smooth_size.sv
tb/sv/tb.sv
